/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the queue RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define OQRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define OQRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OQRM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define OQRM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/oqrm_pkg.sv */
// Package of types, codes and widths shared by the ordered queue modules.
package oqrm_pkg;

	// Default number of queue slots.
	parameter int QUEUE_DEPTH_DEF = 16;

	// Fixed field widths of the beats.
	localparam int KIND_W   = 2;
	localparam int ENTRY_W  = 16;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Operation codes carried by an input beat.
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH   = 2'd0,
		KIND_POP    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Read address sources for the entry memory.
	typedef enum logic [1:0] {
		RD_ZERO  = 2'd0,
		RD_NEXT  = 2'd1,
		RD_NEXT2 = 2'd2,
		RD_POS   = 2'd3
	} rd_sel_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE     = 3'd0,
		S_EXEC     = 3'd1,
		S_SCAN_CHK = 3'd2,
		S_SHIFT    = 3'd3,
		S_RD_DATA  = 3'd4,
		S_FINISH   = 3'd5
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_push;
		logic    wr_shift;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    idx_clr;
		logic    idx_inc;
		logic    res_set;
		status_t res_status;
		logic    res_from_mem;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  empty;
		logic  full;
		logic  pos_hit;
		logic  match;
		logic  idx_last;
		logic  idx_last2;
	} sts_t;

endpackage

/* hw/rtl/ordered_queue_with_remove_by_id_top.sv */
// Usage of the ordered identifier queue:
// An input beat (in_valid, in_stall; kind, entry_id, position) asks for a push at the
// tail, a pop of the head, the removal of the first matching identifier, or a read
// at a position counted from the head. Every input beat gives exactly one output
// beat (out_valid, out_stall; status, entry_out, count, is_empty), in order.
// One item is worked on at a time; in_stall is low only while the block is idle.
// A push writes the tail slot and a read fetches the slot at its position; a pop or a
// removal compares entries from the head up to the first match (a pop takes the head),
// then moves each later entry one slot towards the head; a removal that misses compares
// every entry. The block returns to idle before it accepts the next beat. The single read
// and single write port of the entry memory set the pace: one entry is compared or moved per cycle.
// A result is held in an output register; when the receiver stalls, the next item
// is still accepted and worked on, and waits at its end until the register frees.
// Reset (arst_n low) empties the queue and drops any pending result; the entry
// memory is not cleared, as only slots below the count are ever read.
module ordered_queue_with_remove_by_id_top import oqrm_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [ENTRY_W-1:0]  entry_id,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [ENTRY_W-1:0]  entry_out,
	output logic [COUNT_W-1:0]  count,
	output logic                is_empty
);

	cmd_t cmd;
	sts_t sts;

	// Operation sequencer.
	oqrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Entry storage and result registers.
	oqrm_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.kind     (kind),
		.entry_id (entry_id),
		.position (position),
		.cmd      (cmd),
		.sts      (sts),
		.status   (status),
		.entry_out(entry_out),
		.count    (count),
		.is_empty (is_empty)
	);

endmodule

/* hw/rtl/oqrm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module oqrm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/oqrm_dp.sv */
// Datapath of the ordered queue: item registers, entry memory, counters and result registers.
`include "assert_macros.svh"
module oqrm_dp import oqrm_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [KIND_W-1:0]  kind,
	input  logic [ENTRY_W-1:0] entry_id,
	input  logic [POS_W-1:0]   position,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic [STATUS_W-1:0] status,
	output logic [ENTRY_W-1:0] entry_out,
	output logic [COUNT_W-1:0] count,
	output logic               is_empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	kind_t              kind_q;
	logic [ENTRY_W-1:0] id_q;
	logic [POS_W-1:0]   pos_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	status_t            res_status_q;
	logic [ENTRY_W-1:0] res_entry_q;
	status_t            out_status_q;
	logic [ENTRY_W-1:0] out_entry_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_empty_q;

	logic [CW:0]          idx_p1;
	logic [CW:0]          idx_p2;
	logic [CW:0]          count_w;
	logic [PW-1:0]        pos_w;
	logic [PW-1:0]        count_pw;
	logic [CW+COUNT_W-1:0] count_ext;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic [ENTRY_W-1:0]   rd_data;

	// Item registers, loaded when a beat is accepted.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind_t'(kind);
			id_q   <= entry_id;
			pos_q  <= position;
		end
	end

	// Entry count and the scan/shift index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Index arithmetic and comparisons.
	assign idx_p1   = {1'b0, idx_q} + 1'b1;
	assign idx_p2   = {1'b0, idx_q} + 2'd2;
	assign count_w  = {1'b0, count_q};
	assign pos_w    = PW'(pos_q);
	assign count_pw = PW'(count_q);

	// Memory address and data selection.
	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO:  rd_addr = '0;
			RD_NEXT:  rd_addr = idx_p1[AW-1:0];
			RD_NEXT2: rd_addr = idx_p2[AW-1:0];
			RD_POS:   rd_addr = pos_w[AW-1:0];
			default:  rd_addr = '0;
		endcase
	end

	assign wr_addr = cmd.wr_push ? count_q[AW-1:0] : idx_q[AW-1:0];
	assign wr_data = cmd.wr_push ? id_q : rd_data;

	oqrm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_push | cmd.wr_shift),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Status towards the controller.
	always_comb begin
		sts.kind      = kind_q;
		sts.empty     = (count_q == '0);
		sts.full      = (count_q == DEPTH_C);
		sts.pos_hit   = (pos_w < count_pw);
		sts.match     = (rd_data == id_q);
		sts.idx_last  = (idx_p1 == count_w);
		sts.idx_last2 = (idx_p2 == count_w);
	end

	// Result of the item in progress.
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_entry_q  <= cmd.res_from_mem ? rd_data : '0;
		end
	end

	// Output register; the count is reported modulo the field width.
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
			out_count_q  <= count_ext[COUNT_W-1:0];
			out_empty_q  <= (count_q == '0);
		end
	end

	assign status    = out_status_q;
	assign entry_out = out_entry_q;
	assign count     = out_count_q;
	assign is_empty  = out_empty_q;

	// Checks on the count and on memory writes.
	`OQRM_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= DEPTH_C, "count above depth")
	`OQRM_ASSERT_IMP(a_dec_nonzero, clk, arst_n, cmd.cnt_dec, count_q != '0, "count underflow")
	`OQRM_ASSERT_IMP(a_shift_inside, clk, arst_n, cmd.wr_shift, idx_p1 < count_w, "shift past tail")

endmodule

/* hw/rtl/oqrm_ctrl.sv */
// Controller state machine of the ordered queue: sequences each operation and the output beat.
`include "assert_macros.svh"
module oqrm_ctrl import oqrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.kind)
					KIND_PUSH: begin
						cmd.res_set = 1'b1;
						if (sts.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.res_status = ST_OK;
							cmd.wr_push    = 1'b1;
							cmd.cnt_inc    = 1'b1;
						end
						state_d = S_FINISH;
					end
					KIND_POP, KIND_REMOVE: begin
						if (sts.empty) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_MISS;
							state_d        = S_FINISH;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.rd_sel  = RD_ZERO;
							cmd.idx_clr = 1'b1;
							state_d     = S_SCAN_CHK;
						end
					end
					KIND_READ: begin
						if (sts.pos_hit) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_RD_DATA;
						end else begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_MISS;
							state_d        = S_FINISH;
						end
					end
					default: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_MISS;
						state_d        = S_FINISH;
					end
				endcase
			end
			S_SCAN_CHK: begin
				// A pop always takes the head; a removal takes the first match.
				if (sts.kind == KIND_POP || sts.match) begin
					cmd.res_set      = 1'b1;
					cmd.res_status   = ST_OK;
					cmd.res_from_mem = 1'b1;
					if (sts.idx_last) begin
						cmd.cnt_dec = 1'b1;
						state_d     = S_FINISH;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_NEXT;
						state_d    = S_SHIFT;
					end
				end else if (sts.idx_last) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_MISS;
					state_d        = S_FINISH;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_NEXT;
					cmd.idx_inc = 1'b1;
				end
			end
			S_SHIFT: begin
				// Move one entry a slot towards the head per cycle.
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				if (sts.idx_last2) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT2;
				end
			end
			S_RD_DATA: begin
				cmd.res_set      = 1'b1;
				cmd.res_status   = ST_OK;
				cmd.res_from_mem = 1'b1;
				state_d          = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Checks on command consistency and the output slot.
	`OQRM_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, out_free, "result overwritten")
	`OQRM_ASSERT_IMP(a_inc_dec, clk, arst_n, cmd.cnt_inc, !cmd.cnt_dec, "count inc and dec together")
	`OQRM_ASSERT_IMP(a_push_room, clk, arst_n, cmd.wr_push, sts.kind == KIND_PUSH && !sts.full, "push into full queue")
	`OQRM_ASSERT_NXT(a_load_valid, clk, arst_n, cmd.out_load, out_valid_q, "loaded result not shown")

endmodule
